// ===== rtl/tfde_pkg.sv =====
// ----------------------------------------------------------------------------
// Text framebuffer package
// Shared widths, command codes and the 5x7 font table.
// ----------------------------------------------------------------------------
package tfde_pkg;

  localparam int ScreenWidth  = 128;
  localparam int ScreenHeight = 64;
  localparam int PageCount    = ScreenHeight / 8;
  localparam int StoreBytes   = ScreenWidth * PageCount;
  localparam int ColW         = $clog2(ScreenWidth);
  localparam int PageW        = $clog2(PageCount);
  localparam int AddrW        = $clog2(StoreBytes);
  localparam int WordCount    = ScreenWidth / 8;
  localparam int WordW        = $clog2(WordCount);

  localparam logic [2:0] FuncClear = 3'd0;
  localparam logic [2:0] FuncPixel = 3'd1;
  localparam logic [2:0] FuncChar  = 3'd2;
  localparam logic [2:0] FuncHline = 3'd3;
  localparam logic [2:0] FuncFlush = 3'd4;

  localparam logic [7:0] CmdPageBase = 8'hB0;
  localparam logic [7:0] CmdColLow   = 8'h02;
  localparam logic [7:0] CmdColHigh  = 8'h10;
  localparam logic [7:0] CharFirst   = 8'd32;
  localparam logic [7:0] CharLast    = 8'd126;

  typedef struct packed {
    logic [2:0] func;
    logic signed [8:0] pos_x;
    logic signed [8:0] pos_y;
    logic       ink;
    logic [7:0] char_code;
    logic [7:0] line_width;
    logic [2:0] page_index;
  } cmd_t;

  typedef struct packed {
    logic        word_kind;
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic        last_word;
  } res_t;

  function automatic logic [7:0] reverse_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = b[7 - i];
    return r;
  endfunction

  function automatic logic [39:0] glyph(input logic [6:0] idx);
    logic [39:0] g;
    case (idx)
      7'd0: g = 40'h0000000000;  7'd1: g = 40'h00005F0000;  7'd2: g = 40'h0007000700;
      7'd3: g = 40'h147F147F14;  7'd4: g = 40'h242A7F2A12;  7'd5: g = 40'h2313086462;
      7'd6: g = 40'h3649552250;  7'd7: g = 40'h0005030000;  7'd8: g = 40'h001C224100;
      7'd9: g = 40'h0041221C00;  7'd10: g = 40'h14083E0814; 7'd11: g = 40'h08083E0808;
      7'd12: g = 40'h0050300000; 7'd13: g = 40'h0808080808; 7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402; 7'd16: g = 40'h3E5149453E; 7'd17: g = 40'h00427F4000;
      7'd18: g = 40'h4261514946; 7'd19: g = 40'h2141454B31; 7'd20: g = 40'h1814127F10;
      7'd21: g = 40'h2745454539; 7'd22: g = 40'h3C4A494930; 7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936; 7'd25: g = 40'h064949291E; 7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000; 7'd28: g = 40'h0814224100; 7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0041221408; 7'd31: g = 40'h0201510906; 7'd32: g = 40'h324979413E;
      7'd33: g = 40'h7E1111117E; 7'd34: g = 40'h7F49494936; 7'd35: g = 40'h3E41414122;
      7'd36: g = 40'h7F4141221C; 7'd37: g = 40'h7F49494941; 7'd38: g = 40'h7F09090901;
      7'd39: g = 40'h3E4149497A; 7'd40: g = 40'h7F0808087F; 7'd41: g = 40'h00417F4100;
      7'd42: g = 40'h2040413F01; 7'd43: g = 40'h7F08142241; 7'd44: g = 40'h7F40404040;
      7'd45: g = 40'h7F020C027F; 7'd46: g = 40'h7F0408107F; 7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h7F09090906; 7'd49: g = 40'h3E4151215E; 7'd50: g = 40'h7F09192946;
      7'd51: g = 40'h4649494931; 7'd52: g = 40'h01017F0101; 7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F; 7'd55: g = 40'h3F4038403F; 7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807; 7'd58: g = 40'h6151494543; 7'd59: g = 40'h007F414100;
      7'd60: g = 40'h0204081020; 7'd61: g = 40'h0041417F00; 7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040; 7'd64: g = 40'h0001020400; 7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7F48444438; 7'd67: g = 40'h3844444420; 7'd68: g = 40'h384444487F;
      7'd69: g = 40'h3854545418; 7'd70: g = 40'h087E090102; 7'd71: g = 40'h0C5252523E;
      7'd72: g = 40'h7F08040478; 7'd73: g = 40'h00447D4000; 7'd74: g = 40'h2040443D00;
      7'd75: g = 40'h7F10284400; 7'd76: g = 40'h00417F4000; 7'd77: g = 40'h7C04180478;
      7'd78: g = 40'h7C08040478; 7'd79: g = 40'h3844444438; 7'd80: g = 40'h7C14141408;
      7'd81: g = 40'h081414187C; 7'd82: g = 40'h7C08040408; 7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043F444020; 7'd85: g = 40'h3C4040207C; 7'd86: g = 40'h1C2040201C;
      7'd87: g = 40'h3C4030403C; 7'd88: g = 40'h4428102844; 7'd89: g = 40'h0C5050503C;
      7'd90: g = 40'h4464544C44; 7'd91: g = 40'h0008364100; 7'd92: g = 40'h00007F0000;
      7'd93: g = 40'h0041360800; 7'd94: g = 40'h0804081008;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/text_framebuffer_drawing_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Text framebuffer drawing engine
// Page framebuffer with clear, pixel, glyph and line drawing and page flush.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)                            | tuser / tlast
// s_axis  | in  | func,pos_x,pos_y,ink,char_code,line_width,page_index | -
// m_axis  | out | payload[63:0], byte_count[3:0]                       | word_kind / tlast
// cfg     | in  | rotate_half_turn                                     | -
// Every drawn pixel is one read-modify-write of its store byte (address,
// read, write). A flush sends one command word, then 16 data words of 8
// bytes, each byte read from the store (fetch, wait, collect) and each word
// then loaded into the output; the flush is stalled further by m_axis_tready.
// Reset starts a clearing pass over the whole store; s_axis_tready stays low during it.
// ----------------------------------------------------------------------------
module text_framebuffer_drawing_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // func,pos_x,pos_y,ink,char_code,line_width,page_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // payload, byte_count
  output logic        m_axis_tuser,   // word_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import tfde_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StClear, StAddr, StRead, StWrite, StCmd, StFetch, StFetchWait,
    StCollect, StOut
  } state_e;

  state_e          state_q;
  logic            rot_q;
  cmd_t            cmd_q;
  cmd_t            in_cmd;
  logic [AddrW-1:0] cnt_q;
  logic [39:0]     gl_q;
  logic signed [9:0] px_q, py_q;
  logic [3:0]      col_q;
  logic [2:0]      row_q;
  logic            val_q;
  logic [7:0]      mask_q;
  logic            bits_q;
  logic [AddrW-1:0] addr_q;
  logic [WordW-1:0] word_q;
  logic [3:0]      byte_q;
  logic [63:0]     pay_q;
  logic [63:0]     acc_q;
  logic            kind_q, last_q, mvalid_q;
  logic            out_free, out_load;
  logic            we;
  logic [AddrW-1:0] waddr;
  logic [7:0]      wdata, rdata;
  logic [PageW-1:0] src_page;
  logic [ColW-1:0] fcol;
  logic [ColW:0]   fcol_w;
  logic [7:0]      code_adj;

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {4'd0, (kind_q ? 4'd8 : 4'd3), pay_q};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

  assign in_cmd = cmd_t'({s_axis_tdata[2:0], s_axis_tdata[11:3], s_axis_tdata[20:12],
                          s_axis_tdata[21], s_axis_tdata[29:22], s_axis_tdata[37:30],
                          s_axis_tdata[40:38]});

  assign out_free = !mvalid_q || m_axis_tready;
  assign out_load = out_free && (state_q == StCmd || state_q == StOut);

  assign src_page = rot_q ? PageW'(PageCount - 1 - int'(cmd_q.page_index))
                          : cmd_q.page_index[PageW-1:0];
  assign fcol_w   = (ColW+1)'(word_q[WordW-1:0]) * (ColW+1)'(8) + (ColW+1)'(byte_q[2:0]);
  assign fcol     = rot_q ? ColW'(ScreenWidth - 1) - fcol_w[ColW-1:0] : fcol_w[ColW-1:0];
  assign code_adj = (cmd_q.char_code < CharFirst || cmd_q.char_code > CharLast)
                    ? 8'd0 : cmd_q.char_code - CharFirst;

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = val_q ? (rdata | mask_q) : (rdata & ~mask_q);
    if (state_q == StClear) begin
      we = 1'b1; waddr = cnt_q[AddrW-1:0]; wdata = 8'd0;
    end else if (state_q == StWrite && bits_q) begin
      we = 1'b1;
    end
  end

  tfde_ram #(.Width(8), .Depth(StoreBytes)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  // Current pixel coordinate from glyph/line cursor
  logic signed [9:0] cx, cy;
  logic              inb, gbit;
  always_comb begin
    cx   = px_q + 10'(col_q);
    cy   = py_q + 10'(row_q);
    if (cmd_q.func == FuncHline) cx = px_q + 10'(cnt_q[7:0]);
    if (cmd_q.func != FuncChar) cy = py_q;
    inb  = cx >= 0 && cx < 10'(ScreenWidth) && cy >= 0 && cy < 10'(ScreenHeight);
    gbit = (col_q == 4'd5) ? 1'b0 : gl_q[8*(4 - int'(col_q[2:0])) + int'(row_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      cnt_q    <= '0;
      rot_q    <= 1'b0;
      mvalid_q <= 1'b0;
      bits_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) rot_q <= cfg_data_i;
      if (out_load) mvalid_q <= 1'b1;
      else if (m_axis_tready) mvalid_q <= 1'b0;
      case (state_q)
        StIdle: if (s_axis_tvalid) begin
          cmd_q <= in_cmd;
          px_q  <= 10'(in_cmd.pos_x);
          py_q  <= 10'(in_cmd.pos_y);
          col_q <= '0; row_q <= '0; cnt_q <= '0;
          word_q <= '0; byte_q <= '0;
          case (in_cmd.func)
            FuncClear: state_q <= StClear;
            FuncPixel, FuncChar: state_q <= StAddr;
            FuncHline: state_q <= (in_cmd.line_width == 8'd0) ? StIdle : StAddr;
            FuncFlush: state_q <= (int'(in_cmd.page_index) < PageCount) ? StCmd : StIdle;
            default: state_q <= StIdle;
          endcase
        end
        StClear: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[AddrW-1:0] == AddrW'(StoreBytes - 1)) begin
            cnt_q <= '0; state_q <= StIdle;
          end
        end
        StAddr: begin
          gl_q   <= glyph(code_adj[6:0]);
          addr_q <= AddrW'(cy[9:3]) * AddrW'(ScreenWidth) + AddrW'(cx[ColW-1:0]);
          mask_q <= 8'd1 << cy[2:0];
          bits_q <= inb;
          state_q <= StRead;
        end
        StRead: begin
          case (cmd_q.func)
            FuncPixel: val_q <= cmd_q.ink;
            FuncChar:  val_q <= gbit ^ cmd_q.ink;
            default:   val_q <= 1'b1;
          endcase
          state_q <= StWrite;
        end
        StWrite: begin
          state_q <= StAddr;
          case (cmd_q.func)
            FuncChar: begin
              if (row_q == 3'd6) begin
                row_q <= '0; col_q <= col_q + 1'b1;
                if (col_q == 4'd5) state_q <= StIdle;
              end else row_q <= row_q + 1'b1;
            end
            FuncHline: begin
              cnt_q <= cnt_q + 1'b1;
              if (cnt_q[7:0] == cmd_q.line_width - 8'd1) state_q <= StIdle;
            end
            default: state_q <= StIdle;
          endcase
        end
        StCmd: if (out_free) begin
          pay_q <= {40'd0, CmdColHigh, CmdColLow, CmdPageBase + {5'd0, cmd_q.page_index}};
          kind_q <= 1'b0; last_q <= 1'b0;
          state_q <= StFetch;
        end
        StFetch: begin
          addr_q  <= AddrW'(src_page) * AddrW'(ScreenWidth) + AddrW'(fcol);
          state_q <= StFetchWait;
        end
        StFetchWait: state_q <= StCollect;
        StCollect: begin
          acc_q <= {rot_q ? reverse_byte(rdata) : rdata, acc_q[63:8]};
          byte_q <= byte_q + 1'b1;
          state_q <= (byte_q == 4'd7) ? StOut : StFetch;
        end
        StOut: if (out_free) begin
          pay_q <= acc_q;
          kind_q <= 1'b1;
          last_q <= (word_q[WordW-1:0] == WordW'(WordCount - 1));
          byte_q <= '0; word_q <= word_q + 1'b1;
          state_q <= (word_q[WordW-1:0] == WordW'(WordCount - 1)) ? StIdle : StFetch;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !s_axis_tready) else $error("ready while busy");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped");
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser) else $error("tlast on command");
endmodule

// ===== rtl/tfde_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module tfde_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== bench/text_framebuffer_drawing_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Text framebuffer drawing engine testbench
// Drives drawing and flush items on the input stream and predicts every
// flushed word from a shadow framebuffer. It checks each output word field by
// field, in order, with and without random idling on both streams, in both rotations.
// ----------------------------------------------------------------------------
module text_framebuffer_drawing_engine_unit_tb;
  import tfde_pkg::*;

  localparam logic [2:0] FuncSpare5 = 3'd5;
  localparam logic [2:0] FuncSpare6 = 3'd6;
  localparam logic [2:0] FuncSpare7 = 3'd7;
  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 1300;

  localparam logic [39:0] FontRom [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  logic [7:0] shadow_fb [StoreBytes];
  logic       shadow_rotate;
  res_t       pending_words [$];
  int         errors;
  int         cycles;
  bit         steady;

  text_framebuffer_drawing_engine_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic void plot(int x, int y, bit on);
    int idx;
    if (x < 0 || x >= ScreenWidth || y < 0 || y >= ScreenHeight) return;
    idx = (y / 8) * ScreenWidth + x;
    shadow_fb[idx][y % 8] = on;
  endfunction

  function automatic void apply_cmd(cmd_t c);
    int x;
    int y;
    int code;
    int src;
    logic [7:0] col_bits;
    logic [7:0] b;
    res_t r;
    x = c.pos_x;
    y = c.pos_y;
    case (c.func)
      FuncClear: foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      FuncPixel: plot(x, y, c.ink);
      FuncChar: begin
        code = c.char_code;
        if (code < CharFirst || code > CharLast) code = CharFirst;
        for (int col = 0; col < 5; col++) begin
          col_bits = FontRom[code - CharFirst][39 - 8 * col -: 8];
          for (int row = 0; row < 7; row++) plot(x + col, y + row, col_bits[row] ^ c.ink);
        end
        for (int row = 0; row < 7; row++) plot(x + 5, y + row, c.ink);
      end
      FuncHline: for (int i = 0; i < c.line_width; i++) plot(x + i, y, 1'b1);
      FuncFlush: begin
        if (c.page_index >= PageCount) return;
        src = shadow_rotate ? PageCount - 1 - c.page_index : c.page_index;
        r.word_kind = 1'b0;
        r.payload = {40'h0, CmdColHigh, CmdColLow, CmdPageBase + 8'(c.page_index)};
        r.byte_count = 4'd3;
        r.last_word = 1'b0;
        pending_words.push_back(r);
        for (int w = 0; w < WordCount; w++) begin
          r.word_kind = 1'b1;
          r.byte_count = 4'd8;
          r.last_word = (w == WordCount - 1);
          for (int k = 0; k < 8; k++) begin
            if (shadow_rotate) begin
              b = shadow_fb[src * ScreenWidth + ScreenWidth - 1 - (w * 8 + k)];
              for (int j = 0; j < 8; j++) r.payload[8 * k + j] = b[7 - j];
            end else begin
              r.payload[8 * k +: 8] = shadow_fb[src * ScreenWidth + w * 8 + k];
            end
          end
          pending_words.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] f, int x, int y, bit on, int code,
                                    int width, int page);
    cmd_t c;
    c.func = f;
    c.pos_x = 9'(x);
    c.pos_y = 9'(y);
    c.ink = on;
    c.char_code = 8'(code);
    c.line_width = 8'(width);
    c.page_index = 3'(page);
    return c;
  endfunction

  task automatic send_cmd(cmd_t c);
    if (!steady && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, c.page_index, c.line_width, c.char_code, c.ink,
                     c.pos_y, c.pos_x, c.func};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_cmd(c);
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_rotation(bit v);
    drain_and_settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_rotate = v;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("text_framebuffer_drawing_engine_unit test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, actual kind %0b payload %h count %0d last %0b",
                 $time, m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tlast);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tuser !== want.word_kind) begin
          $display("%0t: word_kind expected %0b actual %0b", $time, want.word_kind,
                   m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[63:0] !== want.payload) begin
          $display("%0t: payload expected %h actual %h", $time, want.payload,
                   m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[67:64] !== want.byte_count) begin
          $display("%0t: byte_count expected %0d actual %0d", $time, want.byte_count,
                   m_axis_tdata[67:64]);
          errors++;
        end
        if (m_axis_tlast !== want.last_word) begin
          $display("%0t: last_word expected %0b actual %0b", $time, want.last_word,
                   m_axis_tlast);
          errors++;
        end
      end
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 35);
  end

  task automatic test_blank_after_reset();
    send_cmd(make_cmd(FuncFlush, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(FuncFlush, 0, 0, 0, 0, 0, PageCount - 1));
  endtask

  task automatic test_pixels();
    send_cmd(make_cmd(FuncPixel, 0, 0, 1, 0, 0, 0));
    send_cmd(make_cmd(FuncPixel, ScreenWidth - 1, ScreenHeight - 1, 1, 0, 0, 0));
    send_cmd(make_cmd(FuncPixel, -1, 5, 1, 0, 0, 0));
    send_cmd(make_cmd(FuncPixel, 255, -256, 1, 0, 0, 0));
    send_cmd(make_cmd(FuncPixel, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(FuncFlush, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_glyphs();
    send_cmd(make_cmd(FuncChar, 10, 2, 0, "A", 0, 0));
    send_cmd(make_cmd(FuncChar, 20, 3, 1, CharLast, 0, 0));
    send_cmd(make_cmd(FuncChar, 30, 1, 1, 31, 0, 0));
    send_cmd(make_cmd(FuncChar, 40, 0, 1, 255, 0, 0));
    send_cmd(make_cmd(FuncChar, -3, -2, 0, "#", 0, 0));
    send_cmd(make_cmd(FuncChar, ScreenWidth - 3, 60, 1, "W", 0, 0));
    send_cmd(make_cmd(FuncFlush, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_lines();
    send_cmd(make_cmd(FuncHline, 5, 20, 0, 0, 0, 0));
    send_cmd(make_cmd(FuncHline, -100, 17, 0, 0, 255, 0));
    send_cmd(make_cmd(FuncHline, 120, 23, 0, 0, 20, 0));
    send_cmd(make_cmd(FuncSpare5, 3, 3, 1, 0, 9, 0));
    send_cmd(make_cmd(FuncSpare6, 3, 3, 1, 0, 9, 0));
    send_cmd(make_cmd(FuncSpare7, 3, 3, 1, 0, 9, 0));
    send_cmd(make_cmd(FuncFlush, 0, 0, 0, 0, 0, 2));
  endtask

  task automatic test_half_turn();
    write_rotation(1'b1);
    send_cmd(make_cmd(FuncFlush, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(FuncFlush, 0, 0, 0, 0, 0, PageCount - 1));
    send_cmd(make_cmd(FuncClear, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(FuncFlush, 0, 0, 0, 0, 0, 5));
  endtask

  task automatic test_random(int count);
    cmd_t c;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      c = make_cmd(FuncPixel, 0, 0, 0, 0, 0, 0);
      c.ink = 1'($urandom_range(1));
      c.char_code = 8'($urandom_range(255));
      c.page_index = 3'($urandom_range(7));
      if ($urandom_range(9) < 8) begin
        c.pos_x = 9'($urandom_range(ScreenWidth + 8) - 8);
        c.pos_y = 9'($urandom_range(ScreenHeight + 8) - 8);
        c.line_width = 8'($urandom_range(40));
      end else begin
        c.pos_x = 9'($urandom_range(511));
        c.pos_y = 9'($urandom_range(511));
        c.line_width = 8'($urandom_range(255));
      end
      if (pick < 28) c.func = FuncPixel;
      else if (pick < 58) c.func = FuncChar;
      else if (pick < 78) c.func = FuncHline;
      else if (pick < 94) c.func = FuncFlush;
      else if (pick < 96) c.func = FuncClear;
      else c.func = 3'(FuncSpare5 + $urandom_range(2));
      send_cmd(c);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    errors = 0;
    cycles = 0;
    steady = 1'b0;
    shadow_rotate = 1'b0;
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_blank_after_reset();
    test_pixels();
    test_glyphs();
    test_lines();
    test_half_turn();
    write_rotation(1'b0);
    test_random(110);
    write_rotation(1'b1);
    steady = 1'b1;
    test_random(90);
    steady = 1'b0;
    write_rotation(1'b0);
    test_random(110);
    drain_and_settle();
    if (errors == 0) begin
      $display("text_framebuffer_drawing_engine_unit test passed");
    end else begin
      $display("text_framebuffer_drawing_engine_unit test failed");
    end
    $finish;
  end

endmodule
